// File: rtl/pipt_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-primitive test package
// Shared constants, register indexes, shape codes and the flag bundle that
// travels down the test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pipt_pkg;

  // Default point coordinate width, signed Q8.8 at 16 bits.
  localparam int PIPT_COORD_WIDTH = 16;

  // Register file geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int LANE_W     = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_POINT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_A    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_LENGTH = 3'd6;

  // Shape codes.
  localparam logic [2:0] MODE_BOX       = 3'd0;
  localparam logic [2:0] MODE_ROT_BOX   = 3'd1;
  localparam logic [2:0] MODE_CYLINDER  = 3'd2;
  localparam logic [2:0] MODE_CYL_TWO   = 3'd3;
  localparam logic [2:0] MODE_SPHERE    = 3'd4;
  localparam logic [2:0] MODE_ELLIPSOID = 3'd5;

  // Number of register stages from input to output.
  localparam int NUM_STAGES = 10;

  // Per-shape partial verdicts carried with each item.
  typedef struct packed {
    logic box_ok;
    logic rot_ok;
    logic sph_ok;
    logic ell_ok;
    logic sym_ok;
    logic two_ok;
  } pipt_flags_t;

  // One signed 16-bit lane of a packed triple.
  function automatic logic signed [LANE_W-1:0] lane(input logic [CFG_DATA_W-1:0] v,
                                                    input int k);
    return v[k*LANE_W +: LANE_W];
  endfunction

endpackage

`default_nettype wire

// File: rtl/point_in_primitive_test_top.sv
// ----------------------------------------------------------------------------
// Point-in-primitive test
// Pipelined containment test of one 3D point against a configured box,
// rotated box, cylinder, sphere or ellipsoid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall with point_x, point_y, point_z. An item
//   is taken at a rising edge where in_valid is high and in_stall is low.
//   Output channel: out_valid/out_stall with inside_res, one result per item.
//   Configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
//   write only while no item is in flight.
//   The pipeline takes one item every cycle unless in_stall is high; its
//   depth is set by the cylinder path, which needs a dot product, a scale
//   back along the axis and a 52-bit squaring split into partial products
//   over two stages.
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles are squeezed out and a stalled receiver only holds back the
//   input once all ten stages are full.
//   Synchronous reset empties the pipeline and clears the configuration
//   registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_primitive_test_top
  import pipt_pkg::*;
#(
  parameter int COORD_WIDTH = PIPT_COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] point_x,
  input  wire logic signed [COORD_WIDTH-1:0] point_y,
  input  wire logic signed [COORD_WIDTH-1:0] point_z,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               inside_res,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  // Datapath widths.
  localparam int DW   = ((COORD_WIDTH > LANE_W) ? COORD_WIDTH : LANE_W) + 1;
  localparam int PW   = DW + LANE_W;
  localparam int TW   = PW + 2;
  localparam int AW   = TW + LANE_W;
  localparam int EW   = ((AW > DW + 28) ? AW : DW + 28) + 1;
  localparam int LW   = EW / 2;
  localparam int HW   = EW - LW;
  localparam int QW   = 2 * EW + 2;
  localparam int CMPW = (QW > 96) ? QW : 96;
  localparam int QMW  = DW + 17;
  localparam int SSW  = 2 * DW + 2;
  localparam int NS   = NUM_STAGES;

  // Configuration registers.
  logic [2:0]  shape_mode;
  logic [47:0] ref_point;
  logic [47:0] vector_a;
  logic [47:0] vector_b;
  logic [31:0] rotation;
  logic [39:0] radius_sq;
  logic [16:0] axis_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode  <= '0;
      ref_point   <= '0;
      vector_a    <= '0;
      vector_b    <= '0;
      rotation    <= '0;
      radius_sq   <= '0;
      axis_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHAPE_MODE:  shape_mode  <= cfg_data[2:0];
        REG_REF_POINT:   ref_point   <= cfg_data;
        REG_VECTOR_A:    vector_a    <= cfg_data;
        REG_VECTOR_B:    vector_b    <= cfg_data;
        REG_ROTATION:    rotation    <= cfg_data[31:0];
        REG_RADIUS_SQ:   radius_sq   <= cfg_data[39:0];
        REG_AXIS_LENGTH: axis_length <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic signed [LANE_W-1:0] rot_cos, rot_sin;
  assign rot_cos = rotation[15:0];
  assign rot_sin = rotation[31:16];

  // Stage valids and advance enables.
  logic [NS:1] v;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !v[NS] || !out_stall;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: capture the point.
  logic signed [COORD_WIDTH-1:0] p1 [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1[0] <= point_x;
      p1[1] <= point_y;
      p1[2] <= point_z;
    end
  end

  // Stage 2: offset from the reference point and the plain box test.
  logic signed [DW-1:0] d2 [3];
  pipt_flags_t          f2;
  pipt_flags_t          f2_next;

  always_comb begin
    f2_next = '0;
    f2_next.box_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (DW'(p1[i]) < DW'(lane(vector_a, i)) ||
          DW'(p1[i]) > DW'(lane(vector_b, i))) begin
        f2_next.box_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      f2 <= f2_next;
      for (int i = 0; i < 3; i++) begin
        d2[i] <= DW'(p1[i]) - DW'(lane(ref_point, i));
      end
    end
  end

  // Stage 3: all first-level products.
  logic signed [DW-1:0]   d3 [3];
  pipt_flags_t            f3;
  logic signed [PW-1:0]   mxc3, mys3, myc3, mxs3;
  logic signed [PW-1:0]   at3 [3];
  logic signed [2*DW-1:0] ds3 [3];
  logic signed [QMW-1:0]  eq3 [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d3   <= d2;
      f3   <= f2;
      mxc3 <= PW'(d2[0]) * PW'(rot_cos);
      mys3 <= PW'(d2[1]) * PW'(rot_sin);
      myc3 <= PW'(d2[1]) * PW'(rot_cos);
      mxs3 <= PW'(d2[0]) * PW'(rot_sin);
      for (int i = 0; i < 3; i++) begin
        at3[i] <= PW'(d2[i]) * PW'(lane(vector_a, i));
        ds3[i] <= (2*DW)'(d2[i]) * (2*DW)'(d2[i]);
        eq3[i] <= QMW'(d2[i]) * QMW'($signed({1'b0, vector_a[i*LANE_W +: LANE_W]}));
      end
    end
  end

  // Stage 4: rotated coordinates, axial distance, sphere sum, magnitudes.
  logic signed [DW-1:0]  d4 [3];
  pipt_flags_t           f4;
  logic signed [PW:0]    r0_4, r1_4;
  logic signed [TW-1:0]  t4;
  logic [SSW-1:0]        ss4;
  logic [QMW-1:0]        qm4 [3];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      d4   <= d3;
      f4   <= f3;
      r0_4 <= (PW+1)'(mxc3) + (PW+1)'(mys3);
      r1_4 <= (PW+1)'(myc3) - (PW+1)'(mxs3);
      t4   <= TW'(at3[0]) + TW'(at3[1]) + TW'(at3[2]);
      ss4  <= SSW'($unsigned(ds3[0])) + SSW'($unsigned(ds3[1])) + SSW'($unsigned(ds3[2]));
      for (int i = 0; i < 3; i++) begin
        qm4[i] <= eq3[i][QMW-1] ? $unsigned(-eq3[i]) : $unsigned(eq3[i]);
      end
    end
  end

  // Stage 5: rotated box, sphere and length tests; axis times distance.
  logic signed [DW-1:0] d5 [3];
  pipt_flags_t          f5;
  pipt_flags_t          f5_next;
  logic signed [AW-1:0] at5 [3];
  logic [39:0]          esq5 [3];
  logic                 over5;
  logic [TW-1:0]        tmag4;
  logic [63:0]          len4;

  assign tmag4 = t4[TW-1] ? $unsigned(-t4) : $unsigned(t4);
  assign len4  = {33'b0, axis_length, 14'b0};

  always_comb begin
    f5_next = f4;
    f5_next.rot_ok =
      r0_4 >= ((PW+1)'(lane(vector_a, 0)) <<< 14) &&
      r0_4 <= ((PW+1)'(lane(vector_b, 0)) <<< 14) &&
      r1_4 >= ((PW+1)'(lane(vector_a, 1)) <<< 14) &&
      r1_4 <= ((PW+1)'(lane(vector_b, 1)) <<< 14) &&
      d4[2] >= DW'(lane(vector_a, 2)) && d4[2] <= DW'(lane(vector_b, 2));
    f5_next.sph_ok = 64'(ss4) < 64'(radius_sq);
    f5_next.sym_ok = 64'(tmag4) < len4;
    f5_next.two_ok = !t4[TW-1] && (64'($unsigned(t4)) < len4);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      d5 <= d4;
      f5 <= f5_next;
      over5 <= (qm4[0][QMW-1:20] != '0) || (qm4[1][QMW-1:20] != '0) ||
               (qm4[2][QMW-1:20] != '0);
      for (int i = 0; i < 3; i++) begin
        at5[i]  <= AW'(t4) * AW'(lane(vector_a, i));
        esq5[i] <= qm4[i][19:0] * qm4[i][19:0];
      end
    end
  end

  // Stage 6: perpendicular offset magnitude and ellipsoid verdict.
  logic [EW-1:0]        em6 [3];
  pipt_flags_t          f6;
  pipt_flags_t          f6_next;
  logic [41:0]          esum5;
  logic signed [EW-1:0] e5 [3];

  assign esum5 = 42'(esq5[0]) + 42'(esq5[1]) + 42'(esq5[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e5[i] = (EW'(d5[i]) <<< 28) - EW'(at5[i]);
    end
  end

  always_comb begin
    f6_next        = f5;
    f6_next.ell_ok = !over5 && (esum5[41:40] == 2'b00);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      f6 <= f6_next;
      for (int i = 0; i < 3; i++) begin
        em6[i] <= e5[i][EW-1] ? $unsigned(-e5[i]) : $unsigned(e5[i]);
      end
    end
  end

  // Stage 7: partial products of each square.
  logic [2*HW-1:0]   hh7 [3];
  logic [HW+LW-1:0]  hl7 [3];
  logic [2*LW-1:0]   ll7 [3];
  pipt_flags_t       f7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      f7 <= f6;
      for (int i = 0; i < 3; i++) begin
        hh7[i] <= em6[i][EW-1:LW] * em6[i][EW-1:LW];
        hl7[i] <= em6[i][EW-1:LW] * em6[i][LW-1:0];
        ll7[i] <= em6[i][LW-1:0] * em6[i][LW-1:0];
      end
    end
  end

  // Stage 8: recombine each square.
  logic [2*EW-1:0] sq8 [3];
  pipt_flags_t     f8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      f8 <= f7;
      for (int i = 0; i < 3; i++) begin
        sq8[i] <= ((2*EW)'(hh7[i]) << (2*LW)) + ((2*EW)'(hl7[i]) << (LW+1)) +
                  (2*EW)'(ll7[i]);
      end
    end
  end

  // Stage 9: squared perpendicular distance.
  logic [QW-1:0] cs9;
  pipt_flags_t   f9;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      f9  <= f8;
      cs9 <= QW'(sq8[0]) + QW'(sq8[1]) + QW'(sq8[2]);
    end
  end

  // Stage 10: cylinder radius test and shape selection.
  logic cyl_ok9;
  logic verdict9;

  assign cyl_ok9 = CMPW'(cs9) < CMPW'({radius_sq, 56'b0});

  always_comb begin
    case (shape_mode)
      MODE_BOX:       verdict9 = f9.box_ok;
      MODE_ROT_BOX:   verdict9 = f9.rot_ok;
      MODE_CYLINDER:  verdict9 = cyl_ok9 && f9.sym_ok;
      MODE_CYL_TWO:   verdict9 = cyl_ok9 && f9.two_ok;
      MODE_SPHERE:    verdict9 = f9.sph_ok;
      MODE_ELLIPSOID: verdict9 = f9.ell_ok;
      default:        verdict9 = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      inside_res <= verdict9;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pipt_checker.sv
// ----------------------------------------------------------------------------
// Point-in-primitive test checker
// Port-level checks on the test pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pipt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic inside_res
);

  // A held result keeps its value until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inside_res))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  // The input is held back only when the output holds an item it cannot pass on.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // An item offered while the output is not holding a stalled result is taken at once.
  a_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !(out_valid && out_stall) |-> !in_stall)
    else $error("item refused while the output is moving");

endmodule

bind point_in_primitive_test_top pipt_checker u_pipt_checker (.*);

`default_nettype wire
